@@ design/rsps_pkg.sv @@
// Package for the permutation shuffle block: operation codes and sequencer state type.
// No dependencies; imported by rejection_sampled_permutation_shuffle_top, shuffle_result_checker and the testbench top.
package rsps_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_WORD  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam int WORD_BITS = 64;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_FILL    = 6'b000010,
        ST_SCAN    = 6'b000100,
        ST_SWAP_WA = 6'b001000,
        ST_SWAP_WB = 6'b010000,
        ST_RESULT  = 6'b100000
    } state_t;

endpackage

@@ design/rejection_sampled_permutation_shuffle_top.sv @@
// Random permutation builder, one item in flight. A start transfer writes the store with
// the identity, one entry a cycle. A random word is taken in 8-bit chunks, seven per word:
// a rejected chunk is dropped, an accepted one is swapped (read both entries, then write
// each back in turn, as the store has a single write port). A read takes its entry from a
// registered read port. The input stalls while an item is at work; a finished result waits
// in the output register and does not block the next transfer. Results follow item order,
// one per item.
// Depends on rsps_pkg.
module rejection_sampled_permutation_shuffle_top
    import rsps_pkg::*;
#(
    parameter int PERM_SIZE = 252,
    parameter int POS_WIDTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [63:0] random_word,
    input  logic [7:0]  read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        finished,
    output logic [7:0]  positions_filled,
    output logic [7:0]  entry_value
);

    localparam int IDX_W  = (PERM_SIZE > 1) ? $clog2(PERM_SIZE) : 1;
    localparam int CNT_W  = $clog2(PERM_SIZE + 1);
    localparam int CHUNKS = (WORD_BITS / POS_WIDTH) - 1;
    localparam int CH_W   = $clog2(CHUNKS + 1);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [IDX_W-1:0]       fill_reg, fill_next;
    logic [IDX_W-1:0]       part_reg, part_next;
    logic [WORD_BITS-1:0]   word_reg, word_next;
    logic [CH_W-1:0]        chunk_cnt_reg, chunk_cnt_next;
    logic                   is_read_reg, is_read_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   finished_reg, finished_next;
    logic [7:0]             filled_reg, filled_next;
    logic [7:0]             entry_reg, entry_next;

    // store and its two registered read ports
    logic [IDX_W-1:0]       mem [PERM_SIZE];
    logic [IDX_W-1:0]       rd_a_reg, rd_b_reg;
    logic [IDX_W-1:0]       rd_addr_a, rd_addr_b;
    logic                   rd_en;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr, wr_data;

    logic                   in_xfer;
    logic                   out_free;
    logic                   pos_done;
    logic [POS_WIDTH-1:0]   chunk;
    logic                   chunk_ok;

    assign in_xfer  = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign pos_done = (pos_reg == CNT_W'(PERM_SIZE));
    assign chunk    = word_reg[POS_WIDTH-1:0];
    assign chunk_ok = (32'(chunk) < 32'(PERM_SIZE));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr_a = IDX_W'(pos_reg);
        rd_addr_b = IDX_W'(chunk);
        wr_en     = 1'b0;
        wr_addr   = fill_reg;
        wr_data   = fill_reg;
        if (state_reg == ST_IDLE)
        begin
            rd_en     = in_xfer && (operation == OP_READ);
            rd_addr_a = IDX_W'(read_index);
        end
        else if (state_reg == ST_SCAN)
        begin
            rd_en = 1'b1;
        end
        else if (state_reg == ST_FILL)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == ST_SWAP_WA)
        begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(pos_reg);
            wr_data = rd_b_reg;
        end
        else if (state_reg == ST_SWAP_WB)
        begin
            wr_en   = 1'b1;
            wr_addr = part_reg;
            wr_data = rd_a_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        part_next      = part_reg;
        word_next      = word_reg;
        chunk_cnt_next = chunk_cnt_reg;
        is_read_next   = is_read_reg;
        out_valid_next = out_valid_reg && out_stall;
        finished_next  = finished_reg;
        filled_next    = filled_reg;
        entry_next     = entry_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    is_read_next = 1'b0;
                    unique case (operation)
                        OP_START:
                        begin
                            pos_next   = '0;
                            fill_next  = '0;
                            state_next = ST_FILL;
                        end
                        OP_WORD:
                        begin
                            word_next      = random_word;
                            chunk_cnt_next = '0;
                            state_next     = ST_SCAN;
                        end
                        OP_READ:
                        begin
                            is_read_next = (32'(read_index) < 32'(PERM_SIZE));
                            state_next   = ST_RESULT;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                fill_next = fill_reg + IDX_W'(1);
                if (fill_reg == IDX_W'(PERM_SIZE - 1))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                if (pos_done || (chunk_cnt_reg == CH_W'(CHUNKS)))
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    // drop the chunk either way; accepted ones go on to the swap
                    word_next      = word_reg >> POS_WIDTH;
                    chunk_cnt_next = chunk_cnt_reg + CH_W'(1);
                    part_next      = IDX_W'(chunk);
                    if (chunk_ok)
                    begin
                        state_next = ST_SWAP_WA;
                    end
                end
            end
            ST_SWAP_WA:
            begin
                state_next = ST_SWAP_WB;
            end
            ST_SWAP_WB:
            begin
                pos_next   = pos_reg + CNT_W'(1);
                state_next = ST_SCAN;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    finished_next  = pos_done;
                    filled_next    = 8'(pos_reg);
                    entry_next     = is_read_reg ? 8'(rd_a_reg) : 8'd0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg      <= fill_next;
        part_reg      <= part_next;
        word_reg      <= word_next;
        chunk_cnt_reg <= chunk_cnt_next;
        is_read_reg   <= is_read_next;
        finished_reg  <= finished_next;
        filled_reg    <= filled_next;
        entry_reg     <= entry_next;
    end

    assign in_stall         = (state_reg != ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign finished         = finished_reg;
    assign positions_filled = filled_reg;
    assign entry_value      = entry_reg;

`ifndef NO_ASSERTIONS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) <= PERM_SIZE)
        else $error("position counter beyond store size");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result loaded outside the result state");

    a_swap_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAP_WB) |=> (pos_reg == $past(pos_reg) + CNT_W'(1)))
        else $error("position did not advance after a swap");

    a_swap_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAP_WA) |-> (32'(pos_reg) < PERM_SIZE))
        else $error("swap started on a finished permutation");
`endif

endmodule

@@ test/shuffle_result_checker.sv @@
// Result checker for the permutation shuffle block: predicts each transfer's result and compares.
// Depends on rsps_pkg; instantiated beside the block by rejection_sampled_permutation_shuffle_top_tb.
module shuffle_result_checker
    import rsps_pkg::*;
#(
    parameter int PERM_SIZE = 252,
    parameter int POS_WIDTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [63:0] random_word,
    input  logic [7:0]  read_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        finished,
    input  logic [7:0]  positions_filled,
    input  logic [7:0]  entry_value,
    output int          pending_results,
    output int          mismatch_count
);

    localparam int CHUNKS_PER_WORD = WORD_BITS / POS_WIDTH - 1;
    localparam logic [63:0] CHUNK_MASK = (64'd1 << POS_WIDTH) - 64'd1;

    typedef struct packed {
        logic       done;
        logic [7:0] filled;
        logic [7:0] entry;
    } shuffle_result_t;

    logic [7:0]      perm_model [PERM_SIZE];
    int unsigned     fill_pos;
    shuffle_result_t awaited_results [$];
    shuffle_result_t oldest;
    int              error_total;

    // Apply one item to the model store and return the result it causes.
    function automatic shuffle_result_t shuffle_step(logic [1:0] op, logic [63:0] word,
                                                     logic [7:0] idx);
        shuffle_result_t r;
        logic [63:0]     bits;
        int unsigned     chunk;
        logic [7:0]      held;
        int              k;
        r.entry = '0;
        bits = word;
        case (op)
            OP_START:
            begin
                for (k = 0; k < PERM_SIZE; k++)
                    perm_model[k] = k[7:0];
                fill_pos = 0;
            end
            OP_WORD:
            begin
                for (k = 0; k < CHUNKS_PER_WORD; k++)
                begin
                    chunk = int'(bits & CHUNK_MASK);
                    bits = bits >> POS_WIDTH;
                    // drop rejected chunks and everything once the permutation is complete
                    if (fill_pos < PERM_SIZE && chunk < PERM_SIZE)
                    begin
                        held = perm_model[fill_pos];
                        perm_model[fill_pos] = perm_model[chunk];
                        perm_model[chunk] = held;
                        fill_pos++;
                    end
                end
            end
            OP_READ:
            begin
                if (idx < PERM_SIZE)
                    r.entry = perm_model[idx];
            end
            default:
            begin
            end
        endcase
        r.done = (fill_pos >= PERM_SIZE);
        r.filled = fill_pos[7:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_results.delete();
            fill_pos = 0;
            error_total = 0;
            pending_results <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transfer with no result expected");
                    error_total++;
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (finished !== oldest.done)
                    begin
                        $error("finished: expected %0d, actual %0d", oldest.done, finished);
                        error_total++;
                    end
                    if (positions_filled !== oldest.filled)
                    begin
                        $error("positions_filled: expected %0d, actual %0d",
                               oldest.filled, positions_filled);
                        error_total++;
                    end
                    if (entry_value !== oldest.entry)
                    begin
                        $error("entry_value: expected %0d, actual %0d",
                               oldest.entry, entry_value);
                        error_total++;
                    end
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(shuffle_step(operation, random_word, read_index));
            pending_results <= awaited_results.size();
            mismatch_count <= error_total;
        end
    end

endmodule

@@ test/rejection_sampled_permutation_shuffle_top_tb.sv @@
// Testbench top for the permutation shuffle block: clock, reset, stimulus, stalls and verdict.
// Depends on rsps_pkg, rejection_sampled_permutation_shuffle_top and shuffle_result_checker.
module rejection_sampled_permutation_shuffle_top_tb;
    import rsps_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PERM_SIZE = 252;
    localparam int ITEM_TARGET = 1900;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [63:0] random_word;
    logic [7:0]  read_index;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        finished;
    logic [7:0]  positions_filled;
    logic [7:0]  entry_value;

    int pending_results;
    int mismatch_count;
    int send_idle_pct = 13;
    int recv_idle_pct = 68;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int op_count [4] = '{0, 0, 0, 0};

    rejection_sampled_permutation_shuffle_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .random_word      (random_word),
        .read_index       (read_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .finished         (finished),
        .positions_filled (positions_filled),
        .entry_value      (entry_value)
    );

    shuffle_result_checker result_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .random_word      (random_word),
        .read_index       (read_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .finished         (finished),
        .positions_filled (positions_filled),
        .entry_value      (entry_value),
        .pending_results  (pending_results),
        .mismatch_count   (mismatch_count)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is asked for.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_done != holds_asked)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_item(input logic [1:0] op, input logic [63:0] word,
                             input logic [7:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        random_word <= word;
        read_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        op_count[op]++;
    endtask

    // Drop valid and wait until every expected result has been seen.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // Random word with an occasional rejected chunk forced in.
    function automatic logic [63:0] shuffle_word();
        logic [63:0] w;
        int          c;
        w = {$urandom, $urandom};
        for (c = 0; c < 7; c++)
        begin
            if ($urandom_range(15) == 0)
                w[c*8 +: 8] = 8'(PERM_SIZE + $urandom_range(3));
        end
        return w;
    endfunction

    function automatic logic [7:0] pick_index();
        if ($urandom_range(9) == 0)
            return 8'(PERM_SIZE + $urandom_range(3));
        return 8'($urandom_range(PERM_SIZE - 1));
    endfunction

    task automatic send_random_item();
        case ($urandom_range(9)) inside
            0:       send_item(OP_START, shuffle_word(), pick_index());
            1:       send_item(OP_UNUSED, shuffle_word(), pick_index());
            [2:4]:   send_item(OP_READ, shuffle_word(), pick_index());
            default: send_item(OP_WORD, shuffle_word(), pick_index());
        endcase
    endtask

    task automatic build_permutation();
        int word_total;
        int i;
        send_item(OP_START, shuffle_word(), pick_index());
        word_total = $urandom_range(34, 44);
        for (i = 0; i < word_total; i++)
        begin
            send_item(OP_WORD, shuffle_word(), pick_index());
            if ($urandom_range(4) == 0)
                send_item(OP_READ, shuffle_word(), pick_index());
            if ($urandom_range(40) == 0)
                send_item(OP_UNUSED, shuffle_word(), pick_index());
        end
        // tail: words past completion are dropped, reads show the final order
        for (i = $urandom_range(6); i > 0; i--)
            send_item($urandom_range(1) ? OP_READ : OP_WORD, shuffle_word(), pick_index());
    endtask

    initial
    begin
        int phase;
        int i;
        in_valid = 1'b0;
        operation = OP_START;
        random_word = '0;
        read_index = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unused op from reset, range edges of reads, all-accept and all-reject words
        send_item(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        send_item(OP_START, '0, '0);
        send_item(OP_READ, '0, 8'd0);
        send_item(OP_READ, '0, 8'(PERM_SIZE - 1));
        send_item(OP_READ, 64'hFFFF_FFFF_FFFF_FFFF, 8'(PERM_SIZE));
        send_item(OP_READ, '0, 8'hFF);
        send_item(OP_WORD, 64'h0000_0000_0000_0000, '0);
        send_item(OP_WORD, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        send_item(OP_WORD, 64'h00FF_FEFD_FCFF_FEFD, '0);
        send_item(OP_WORD, 64'hA5FB_00FC_01FA_FE02, '0);
        send_item(OP_WORD, 64'h5A0A_1B2C_3D4E_5F60, '0);
        send_item(OP_READ, '0, 8'd1);
        send_item(OP_READ, '0, 8'd2);
        send_item(OP_READ, '0, 8'd251);
        send_item(OP_UNUSED, '0, 8'd5);
        send_item(OP_START, 64'hFFFF_FFFF_FFFF_FFFF, 8'hAA);
        send_item(OP_WORD, 64'hFB01_0203_0405_06FB, 8'h55);
        send_item(OP_READ, '0, 8'd0);
        send_item(OP_READ, '0, 8'd6);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 0 && items_sent >= ITEM_TARGET / 3)
            begin
                wait_for_drain();
                phase = 1;
                send_idle_pct = 68;
                recv_idle_pct = 13;
            end
            else if (phase == 1 && items_sent >= 2 * ITEM_TARGET / 3)
            begin
                wait_for_drain();
                phase = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // keep offering items while the result side holds off
                holds_asked++;
            end
            if ($urandom_range(99) < 85)
                build_permutation();
            else
                for (i = $urandom_range(1, 8); i > 0; i--)
                    send_random_item();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d transfers: %0d starts, %0d words, %0d reads, %0d unused ops,",
                 items_sent, op_count[OP_START], op_count[OP_WORD], op_count[OP_READ],
                 op_count[OP_UNUSED]);
        $display("over three stall patterns and one long result-side hold-off.");
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
design/rsps_pkg.sv
design/rejection_sampled_permutation_shuffle_top.sv
test/shuffle_result_checker.sv
test/rejection_sampled_permutation_shuffle_top_tb.sv
